### hw/rtl/nlms_anc_pkg.sv
package nlms_anc_pkg;

    // Field and register widths
    localparam int ECG_W      = 12;
    localparam int REF_W      = 16;
    localparam int OUT_W      = 16;
    localparam int TAPCNT_W   = 6;
    localparam int STEP_W     = 16;
    localparam int REGZ_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int WEIGHT_W   = 24;
    localparam int AVG_W      = 24;
    localparam int SCNT_W     = 10;

    // Shared multiplier: A covers mu*err (33 bits signed), B covers 16-bit samples
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // |mu * err * x| stays below 2^46
    localparam int DVD_W = 46;

    localparam int MAX_TAPS_DEF = 32;
    localparam int NORM_W_DEF   = 32 + $clog2(MAX_TAPS_DEF);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGULARIZER = 2'd2;

    // Constants
    localparam int MID_SCALE    = 2048;
    localparam int ERR_MAX      = 32767;
    localparam int ERR_MIN      = -32768;
    localparam int WEIGHT_LIMIT = 32'h7FFFFF;
    localparam int CONV_SAMPLES = 512;
    localparam int CONV_POWER   = 1000;
    localparam int DEF_TAPS     = 32;
    localparam int DEF_STEP     = 3277;
    localparam int DEF_REG      = 328;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hw/rtl/nlms_adaptive_noise_canceller.sv
// NLMS adaptive noise canceller, Q15. Each input transaction carries one 12-bit ECG
// sample, one signed reference (motion) sample and an adapt flag, and yields exactly one
// output transaction: the ECG minus mid-scale minus the FIR estimate of the artifact,
// saturated to 16 bits, plus a sticky converged flag. All arithmetic runs through one
// shared signed multiplier and one restoring divider (one quotient bit per cycle) under
// a small sequencer, so the block takes one sample at a time and holds o_in_stall high
// until that sample's result is loaded into the output register. With adapt_enable low a
// sample takes only the FIR pass and the error; with it high a power pass and a per-tap
// divide and weight update follow. A finished result waits in the output register while
// the next sample is already accepted. Configuration (tap count, step size, regularizer)
// must be written through the plain write port while the block is idle; the block itself
// does not enforce this. A zero or oversize tap count falls back to MAX_TAPS, a zero step
// size or regularizer to its default. Weight and history memories read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
module nlms_adaptive_noise_canceller
    import nlms_anc_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ECG_W-1:0]             i_ecg_sample,
    input  logic signed [REF_W-1:0]      i_reference,
    input  logic                         i_adapt_enable,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [OUT_W-1:0]      o_cleaned_sample,
    output logic                         o_converged,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int CW     = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = 40 + AW;
    localparam int PW     = 31 + AW;
    localparam int NW     = PW + 1;

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_F_RD  = 5'd1;
    localparam logic [4:0] S_F_MUL = 5'd2;
    localparam logic [4:0] S_F_ACC = 5'd3;
    localparam logic [4:0] S_ERR   = 5'd4;
    localparam logic [4:0] S_SQ    = 5'd5;
    localparam logic [4:0] S_EMA   = 5'd6;
    localparam logic [4:0] S_P_RD  = 5'd7;
    localparam logic [4:0] S_P_MUL = 5'd8;
    localparam logic [4:0] S_P_ACC = 5'd9;
    localparam logic [4:0] S_MUE   = 5'd10;
    localparam logic [4:0] S_NORM  = 5'd11;
    localparam logic [4:0] S_W_RD  = 5'd12;
    localparam logic [4:0] S_W_MUL = 5'd13;
    localparam logic [4:0] S_W_ST  = 5'd14;
    localparam logic [4:0] S_W_DIV = 5'd15;
    localparam logic [4:0] S_W_WR  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0]                r_state, n_state;
    logic [CW-1:0]             r_k, n_k;
    logic [AW-1:0]             r_ptr;

    logic [TAPCNT_W-1:0]       r_tap_count;
    logic [STEP_W-1:0]         r_step;
    logic [REGZ_W-1:0]         r_regz;

    // Memories and their valid bits
    logic signed [REF_W-1:0]    hist_mem [MAX_TAPS];
    logic signed [WEIGHT_W-1:0] w_mem    [MAX_TAPS];
    logic [MAX_TAPS-1:0]        r_hvld;
    logic [MAX_TAPS-1:0]        r_wvld;
    logic signed [REF_W-1:0]    r_x_raw;
    logic signed [WEIGHT_W-1:0] r_w_raw;
    logic                       r_xv;
    logic                       r_wv;

    logic [ECG_W-1:0]           r_ecg;
    logic                       r_adapt;
    logic signed [ACC_W-1:0]    r_acc;
    logic [PW-1:0]              r_pow;
    logic [NW-1:0]              r_norm;
    logic signed [OUT_W-1:0]    r_err;
    logic signed [32:0]         r_mu_err;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;

    logic [AVG_W-1:0]           r_avg;
    logic [SCNT_W-1:0]          r_cnt;
    logic                       r_conv;

    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out_sample;
    logic                       r_out_conv;

    // Combinational helpers
    logic [CW-1:0]              taps_act;
    logic [STEP_W-1:0]          mu_act;
    logic [REGZ_W-1:0]          eps_act;
    logic [AW-1:0]              ks;
    logic [AW:0]                slot_wrap;
    logic [AW-1:0]              slot;
    logic                       last;
    logic                       in_accept;
    logic                       out_free;
    logic signed [REF_W-1:0]    x;
    logic signed [WEIGHT_W-1:0] w;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    est;
    logic signed [ECG_W:0]      ecg_c;
    logic signed [ACC_W:0]      err_full;
    logic signed [OUT_W-1:0]    err_sat;
    logic [31:0]                sq;
    logic [AVG_W:0]             avg_sum;
    logic [AVG_W-1:0]           avg_nx;
    logic [SCNT_W-1:0]          cnt_nx;
    logic signed [PROD_W-1:0]   prod_mag;
    logic [DVD_W-1:0]           dividend;
    t_div_stat                  div_stat;
    logic [DVD_W-1:0]           div_quo;
    logic signed [DVD_W:0]      q_s;
    logic signed [DVD_W+1:0]    w_sum;
    logic signed [WEIGHT_W-1:0] w_new;

    // Effective configuration: zero or oversize tap count gives MAX_TAPS, zero step or regularizer the default
    always_comb begin
        if (r_tap_count == '0 || 32'(r_tap_count) > MAX_TAPS) begin
            taps_act = CW'(MAX_TAPS);
        end else begin
            taps_act = CW'(r_tap_count);
        end
        mu_act  = (r_step == '0) ? STEP_W'(DEF_STEP) : r_step;
        eps_act = (r_regz == '0) ? REGZ_W'(DEF_REG) : r_regz;
    end

    // Tap k reads history slot (ptr - k) mod MAX_TAPS
    always_comb begin
        ks        = r_k[AW-1:0];
        slot_wrap = {1'b0, r_ptr} + (AW+1)'(MAX_TAPS) - {1'b0, ks};
        slot      = (r_ptr >= ks) ? (r_ptr - ks) : slot_wrap[AW-1:0];
        last      = (r_k == taps_act - 1'b1);
    end

    assign in_accept = (r_state == S_IDLE) && i_in_valid;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign x         = r_xv ? r_x_raw : '0;
    assign w         = r_wv ? r_w_raw : '0;

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_F_MUL: begin
                mul_a = MUL_A_W'(w);
                mul_b = MUL_B_W'(x);
            end
            S_SQ: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_err);
            end
            S_P_MUL: begin
                mul_a = MUL_A_W'(x);
                mul_b = MUL_B_W'(x);
            end
            S_MUE: begin
                mul_a = MUL_A_W'(signed'({1'b0, mu_act}));
                mul_b = MUL_B_W'(r_err);
            end
            S_W_MUL: begin
                mul_a = MUL_A_W'(r_mu_err);
                mul_b = MUL_B_W'(x);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Error: (ecg - mid-scale) - floor(acc / 2^15), saturated
    always_comb begin
        est      = r_acc >>> 15;
        ecg_c    = signed'({1'b0, r_ecg}) - (ECG_W+1)'(MID_SCALE);
        err_full = (ACC_W+1)'(ecg_c) - (ACC_W+1)'(est);
        if (err_full > ERR_MAX) begin
            err_sat = OUT_W'(ERR_MAX);
        end else if (err_full < ERR_MIN) begin
            err_sat = OUT_W'(ERR_MIN);
        end else begin
            err_sat = err_full[OUT_W-1:0];
        end
    end

    // Error power average and sample count
    always_comb begin
        sq      = r_prod[31:0];
        avg_sum = (AVG_W+1)'(r_avg) - (AVG_W+1)'(r_avg[AVG_W-1:8]) + (AVG_W+1)'(sq[31:16]);
        avg_nx  = avg_sum[AVG_W-1:0];
        cnt_nx  = (r_cnt < SCNT_W'(CONV_SAMPLES + 1)) ? r_cnt + 1'b1 : r_cnt;
    end

    // Divider operands and weight update
    always_comb begin
        prod_mag = r_prod[PROD_W-1] ? -r_prod : r_prod;
        dividend = prod_mag[DVD_W-1:0];
        q_s      = r_neg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
        w_sum    = (DVD_W+2)'(w) + (DVD_W+2)'(q_s);
        if (w_sum > WEIGHT_LIMIT) begin
            w_new = WEIGHT_W'(WEIGHT_LIMIT);
        end else if (w_sum < -WEIGHT_LIMIT) begin
            w_new = WEIGHT_W'(-WEIGHT_LIMIT);
        end else begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
    end

    nlms_anc_div #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_W_ST),
        .i_dividend (dividend),
        .i_divisor  (r_norm),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Sequencer: FIR pass, error, then power pass and per-tap divide when adapting
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_F_RD;
                    n_k     = '0;
                end
            end
            S_F_RD:  n_state = S_F_MUL;
            S_F_MUL: n_state = S_F_ACC;
            S_F_ACC: begin
                if (last) begin
                    n_state = S_ERR;
                    n_k     = '0;
                end else begin
                    n_state = S_F_RD;
                    n_k     = r_k + 1'b1;
                end
            end
            S_ERR: n_state = S_SQ;
            S_SQ:  n_state = S_EMA;
            S_EMA: n_state = r_adapt ? S_P_RD : S_OUT;
            S_P_RD:  n_state = S_P_MUL;
            S_P_MUL: n_state = S_P_ACC;
            S_P_ACC: begin
                if (last) begin
                    n_state = S_MUE;
                    n_k     = '0;
                end else begin
                    n_state = S_P_RD;
                    n_k     = r_k + 1'b1;
                end
            end
            S_MUE:   n_state = S_NORM;
            S_NORM:  n_state = S_W_RD;
            S_W_RD:  n_state = S_W_MUL;
            S_W_MUL: n_state = S_W_ST;
            S_W_ST:  n_state = S_W_DIV;
            S_W_DIV: begin
                if (div_stat.done) begin
                    n_state = S_W_WR;
                end
            end
            S_W_WR: begin
                if (last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_W_RD;
                    n_k     = r_k + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_ptr       <= '0;
            r_tap_count <= TAPCNT_W'(DEF_TAPS);
            r_step      <= STEP_W'(DEF_STEP);
            r_regz      <= REGZ_W'(DEF_REG);
            r_hvld      <= '0;
            r_wvld      <= '0;
            r_xv        <= 1'b0;
            r_wv        <= 1'b0;
            r_avg       <= '0;
            r_cnt       <= '0;
            r_conv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_xv    <= r_hvld[slot];
            r_wv    <= r_wvld[ks];

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TAP_COUNT:   r_tap_count <= i_cfg_data[TAPCNT_W-1:0];
                    REG_STEP_SIZE:   r_step      <= i_cfg_data[STEP_W-1:0];
                    REG_REGULARIZER: r_regz      <= i_cfg_data[REGZ_W-1:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_hvld[r_ptr] <= 1'b1;
            end
            if (r_state == S_W_WR) begin
                r_wvld[ks] <= 1'b1;
            end

            // Update the error average and latch the sticky flag
            if (r_state == S_EMA) begin
                r_avg <= avg_nx;
                r_cnt <= cnt_nx;
                if (cnt_nx > SCNT_W'(CONV_SAMPLES) && avg_nx < AVG_W'(CONV_POWER)) begin
                    r_conv <= 1'b1;
                end
            end

            // Load the result and advance the history pointer; drop valid once taken
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_ptr       <= (r_ptr == AW'(MAX_TAPS - 1)) ? '0 : r_ptr + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Memories and datapath
    always_ff @(posedge i_clk) begin
        r_x_raw <= hist_mem[slot];
        r_w_raw <= w_mem[ks];
        r_prod  <= mul_a * mul_b;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    hist_mem[r_ptr] <= i_reference;
                    r_ecg           <= i_ecg_sample;
                    r_adapt         <= i_adapt_enable;
                    r_acc           <= '0;
                    r_pow           <= '0;
                end
            end
            S_F_ACC: r_acc <= r_acc + signed'(r_prod[ACC_W-1:0]);
            S_ERR:   r_err <= err_sat;
            S_P_ACC: r_pow <= r_pow + PW'(r_prod[30:0]);
            S_NORM: begin
                r_mu_err <= r_prod[32:0];
                r_norm   <= NW'(r_pow) + NW'(eps_act);
            end
            S_W_ST: r_neg <= r_prod[PROD_W-1];
            S_W_WR: w_mem[ks] <= w_new;
            S_OUT: begin
                if (out_free) begin
                    r_out_sample <= r_err;
                    r_out_conv   <= r_conv;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_cleaned_sample = r_out_sample;
    assign o_converged      = r_out_conv;

`ifndef SYNTHESIS
    a_wr_only_adapt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_WR) |-> r_adapt)
        else $error("weight write without adaptation");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_W_DIV))
        else $error("divider finished outside its wait state");

    a_conv_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conv |=> r_conv)
        else $error("converged flag dropped");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after load");
`endif

endmodule

### hw/rtl/nlms_anc_div.sv
module nlms_anc_div
    import nlms_anc_pkg::*;
#(
    parameter int DIVIDEND_W = DVD_W,
    parameter int DIVISOR_W  = NORM_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output t_div_stat             o_stat,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  ge;

    // One restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
        ge       = rem_sh >= {1'b0, r_dvs};
        rem_diff = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
